// ----- hw/rtl/sil_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_pkg: shared types and constants of the sorted insertion list
// Table size, field widths, operation and status codes, and the structs
// that travel along the row of cells.
// ----------------------------------------------------------------------------
package sil_pkg;

   // table size and derived widths
   localparam int Capacity = 32;
   localparam int IdxW     = (Capacity > 1) ? $clog2(Capacity) : 1;
   localparam int CntW     = $clog2(Capacity + 1);

   // fixed field widths
   localparam int KeyW    = 18;
   localparam int CoordW  = 16;
   localparam int RootW   = 15;
   localparam int IdW     = 16;
   localparam int HandleW = 16;
   localparam int PosW    = 16;
   localparam int TotalW  = 6;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_FIND   = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   // one table entry
   typedef struct packed {
      logic signed [KeyW-1:0] key;
      logic [IdW-1:0]         id;
      logic [HandleW-1:0]     handle;
   } entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic                   valid;
      op_type                 op;
      logic signed [KeyW-1:0] key;
      logic [IdW-1:0]         id;
      logic [HandleW-1:0]     handle;
      logic [IdxW-1:0]        read_idx;
      logic [CntW-1:0]        count;
      logic                   full;
   } cmd_type;

   // signals handed from a cell to its right neighbor
   typedef struct packed {
      logic               greater;
      logic               hit;
      logic [HandleW-1:0] found_handle;
      logic [HandleW-1:0] read_handle;
   } link_type;

endpackage

// ----- hw/rtl/sorted_insertion_list_unit.sv -----
`timescale 1ns / 1ps
// Latency: a command passes the command registers, then the result registers, before its result strobes.
// Throughput: one command per cycle; busy stays low, the row of cells
// updates every slot together and the count register follows at once.
// Reset: synchronous, clears the entry count and the pipeline strobes;
// entry contents are left as they are and only slots below the count are read.
// The receiver cannot stall: each result word is shown for one cycle.
// ----------------------------------------------------------------------------
// sorted_insertion_list_unit: sorted draw table built as a row of cells
// Insert, remove by id, find by id and read by position on a table kept in
// ascending key order, key = position_y + z_index - root_height.
// ----------------------------------------------------------------------------
module sorted_insertion_list_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_operation,
   input  logic signed [sil_pkg::CoordW-1:0] req_position_y,
   input  logic signed [sil_pkg::CoordW-1:0] req_z_index,
   input  logic [sil_pkg::RootW-1:0]       req_root_height,
   input  logic [sil_pkg::IdW-1:0]         req_object_id,
   input  logic [sil_pkg::HandleW-1:0]     req_picture_handle,
   input  logic [sil_pkg::PosW-1:0]        req_position_index,
   output logic                            rsp_strobe,
   output logic [sil_pkg::HandleW-1:0]     rsp_result_handle,
   output logic [1:0]                      rsp_status,
   output logic [sil_pkg::TotalW-1:0]      rsp_entry_total
);

   localparam int Cap = sil_pkg::Capacity;

   // command stage
   logic                                valid_ff;
   sil_pkg::op_type                     op_ff;
   logic signed [sil_pkg::KeyW-1:0]     key_ff;
   logic [sil_pkg::IdW-1:0]             id_ff;
   logic [sil_pkg::HandleW-1:0]         handle_ff;
   logic [sil_pkg::PosW-1:0]            pos_ff;
   logic signed [sil_pkg::KeyW-1:0]     key_in;

   // table state
   logic [sil_pkg::CntW-1:0]            count_ff;
   logic [sil_pkg::CntW-1:0]            count_in;

   // result stage
   logic                                strobe_ff;
   logic [sil_pkg::HandleW-1:0]         res_handle_ff;
   logic [sil_pkg::HandleW-1:0]         res_handle_in;
   sil_pkg::status_type                 res_status_ff;
   sil_pkg::status_type                 res_status_in;
   logic [sil_pkg::CntW-1:0]            res_count_ff;

   sil_pkg::cmd_type                    cmd;
   sil_pkg::entry_type                  entries [Cap];
   sil_pkg::link_type                   links [Cap+1];
   logic                                accept;
   logic                                full;
   logic                                empty;

   assign accept = start && !busy;
   assign busy   = 1'b0;

   // draw key, sign extended to the key width
   assign key_in = sil_pkg::KeyW'(req_position_y) + sil_pkg::KeyW'(req_z_index)
                   - $signed({{(sil_pkg::KeyW-sil_pkg::RootW){1'b0}}, req_root_height});

   // command registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= sil_pkg::op_type'(req_operation);
         key_ff    <= key_in;
         id_ff     <= req_object_id;
         handle_ff <= req_picture_handle;
         pos_ff    <= req_position_index;
      end
   end

   // broadcast command, read position clamped to the last entry
   always_comb begin
      full         = count_ff == sil_pkg::CntW'(Cap);
      empty        = count_ff == '0;
      cmd.valid    = valid_ff;
      cmd.op       = op_ff;
      cmd.key      = key_ff;
      cmd.id       = id_ff;
      cmd.handle   = handle_ff;
      cmd.count    = count_ff;
      cmd.full     = full;
      if (pos_ff >= sil_pkg::PosW'(count_ff)) begin
         cmd.read_idx = sil_pkg::IdxW'(count_ff - sil_pkg::CntW'(1));
      end else begin
         cmd.read_idx = sil_pkg::IdxW'(pos_ff);
      end
   end

   // row of cells
   assign links[0] = '0;

   for (genvar i = 0; i < Cap; i++) begin : g_cell
      sil_pkg::entry_type left_entry;
      sil_pkg::entry_type right_entry;

      if (i == 0) begin : g_first
         assign left_entry = entries[0];
      end else begin : g_mid_left
         assign left_entry = entries[i-1];
      end

      if (i == Cap - 1) begin : g_last
         assign right_entry = entries[Cap-1];
      end else begin : g_mid_right
         assign right_entry = entries[i+1];
      end

      sil_cell u_cell (
         .clock       (clock),
         .cell_index  (sil_pkg::IdxW'(i)),
         .cmd         (cmd),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .link_in     (links[i]),
         .entry_out   (entries[i]),
         .link_out    (links[i+1])
      );
   end

   // result word and next count
   always_comb begin
      count_in      = count_ff;
      res_handle_in = '0;
      res_status_in = sil_pkg::ST_OK;
      unique case (op_ff)
         sil_pkg::OP_INSERT: begin
            if (full) begin
               res_status_in = sil_pkg::ST_FULL;
            end else begin
               count_in = count_ff + sil_pkg::CntW'(1);
            end
         end
         sil_pkg::OP_REMOVE: begin
            if (links[Cap].hit) begin
               count_in = count_ff - sil_pkg::CntW'(1);
            end else begin
               res_status_in = sil_pkg::ST_NOT_FOUND;
            end
         end
         sil_pkg::OP_FIND: begin
            if (links[Cap].hit) begin
               res_handle_in = links[Cap].found_handle;
            end else begin
               res_status_in = sil_pkg::ST_NOT_FOUND;
            end
         end
         sil_pkg::OP_READ: begin
            if (empty) begin
               res_status_in = sil_pkg::ST_NOT_FOUND;
            end else begin
               res_handle_in = links[Cap].read_handle;
            end
         end
         default: begin
            res_status_in = sil_pkg::ST_OK;
         end
      endcase
   end

   // count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (valid_ff) begin
         count_ff <= count_in;
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_ff) begin
         res_handle_ff <= res_handle_in;
         res_status_ff <= res_status_in;
         res_count_ff  <= count_in;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_result_handle = res_handle_ff;
   assign rsp_status        = res_status_ff;
   assign rsp_entry_total   = sil_pkg::TotalW'(res_count_ff);

endmodule

// ----- hw/rtl/sil_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sil_cell: one slot of the sorted table
// Holds one entry, compares it against the broadcast command and either
// keeps it, takes the new word, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module sil_cell (
   input  logic                           clock,
   input  logic [sil_pkg::IdxW-1:0]       cell_index,
   input  sil_pkg::cmd_type               cmd,
   input  sil_pkg::entry_type             left_entry,
   input  sil_pkg::entry_type             right_entry,
   input  sil_pkg::link_type              link_in,
   output sil_pkg::entry_type             entry_out,
   output sil_pkg::link_type              link_out
);

   sil_pkg::entry_type entry_ff;
   sil_pkg::entry_type entry_in;
   logic               occupied;
   logic               at_tail;
   logic               greater;
   logic               match;
   logic               first_hit;
   logic               read_here;

   // slot compares
   always_comb begin
      occupied    = sil_pkg::CntW'(cell_index) < cmd.count;
      at_tail     = sil_pkg::CntW'(cell_index) == cmd.count;
      greater     = occupied && (entry_ff.key > cmd.key);
      match       = occupied && (entry_ff.id == cmd.id);
      first_hit   = match && !link_in.hit;
      read_here   = cell_index == cmd.read_idx;
   end

   // chain outputs to the right neighbor
   always_comb begin
      link_out.greater      = greater;
      link_out.hit          = link_in.hit | match;
      link_out.found_handle = link_in.found_handle
                              | (first_hit ? entry_ff.handle : '0);
      link_out.read_handle  = link_in.read_handle
                              | (read_here ? entry_ff.handle : '0);
   end

   // next entry
   always_comb begin
      entry_in = entry_ff;
      if (cmd.valid) begin
         unique case (cmd.op)
            sil_pkg::OP_INSERT: begin
               if (!cmd.full) begin
                  if (link_in.greater) begin
                     entry_in = left_entry;
                  end else if (greater || at_tail) begin
                     entry_in.key    = cmd.key;
                     entry_in.id     = cmd.id;
                     entry_in.handle = cmd.handle;
                  end
               end
            end
            sil_pkg::OP_REMOVE: begin
               if (link_in.hit | match) begin
                  entry_in = right_entry;
               end
            end
            sil_pkg::OP_FIND,
            sil_pkg::OP_READ: begin
               entry_in = entry_ff;
            end
            default: begin
               entry_in = entry_ff;
            end
         endcase
      end
   end

   // entry register
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule

// ----- tb/tb_sorted_insertion_list_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_insertion_list_unit: self-checking bench for the sorted draw table
// Drives insert, remove, find and read words through the start/busy port and
// keeps its own copy of the table. Each strobed result is checked field by
// field against the oldest awaited reply. Directed words cover the empty
// table, the key extremes, equal keys, duplicate ids and reads past the end.
// Random rounds then fill the table to the brim and drain it, followed by a
// long mixed run with random idle gaps.
// ----------------------------------------------------------------------------
module tb_sorted_insertion_list_unit;
   import sil_pkg::*;

   localparam int RandomWords = 1950;
   localparam int IdPool      = 16;

   // one command word as the bench sees it
   typedef struct packed {
      op_type                   op;
      logic signed [CoordW-1:0] pos_y;
      logic signed [CoordW-1:0] z_idx;
      logic [RootW-1:0]         root;
      logic [IdW-1:0]           id;
      logic [HandleW-1:0]       handle;
      logic [PosW-1:0]          index;
   } cmd_word_t;

   // one reply word
   typedef struct packed {
      logic [HandleW-1:0] handle;
      status_type         status;
      logic [TotalW-1:0]  total;
   } reply_word_t;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [1:0]                req_operation;
   logic signed [CoordW-1:0]  req_position_y;
   logic signed [CoordW-1:0]  req_z_index;
   logic [RootW-1:0]          req_root_height;
   logic [IdW-1:0]            req_object_id;
   logic [HandleW-1:0]        req_picture_handle;
   logic [PosW-1:0]           req_position_index;
   logic                      rsp_strobe;
   logic [HandleW-1:0]        rsp_result_handle;
   logic [1:0]                rsp_status;
   logic [TotalW-1:0]         rsp_entry_total;

   // shadow copy of the draw table
   logic signed [KeyW-1:0]    key_store[Capacity];
   logic [IdW-1:0]            id_store[Capacity];
   logic [HandleW-1:0]        handle_store[Capacity];
   int                        table_count;

   reply_word_t               awaited_replies[$];
   bit                        idle_enabled;
   int                        mismatch_count;
   int                        words_sent;
   int                        replies_checked;
   int                        op_counts[4];
   int                        full_rejects;
   int                        clamped_reads;
   int                        peak_count;

   sorted_insertion_list_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_position_y     (req_position_y),
      .req_z_index        (req_z_index),
      .req_root_height    (req_root_height),
      .req_object_id      (req_object_id),
      .req_picture_handle (req_picture_handle),
      .req_position_index (req_position_index),
      .rsp_strobe         (rsp_strobe),
      .rsp_result_handle  (rsp_result_handle),
      .rsp_status         (rsp_status),
      .rsp_entry_total    (rsp_entry_total)
   );

   // 4 ns clock
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // watchdog
   initial begin
      #5_000_000;
      $display("timeout: %0d replies still awaited", awaited_replies.size());
      $display("end of test: mismatches");
      $finish;
   end

   // apply one word to the shadow table and return the reply it causes
   function automatic reply_word_t draw_table_apply(cmd_word_t w);
      reply_word_t r;
      int          key_val;
      int          pos;
      int          hit;
      r.handle = '0;
      r.status = ST_OK;
      hit = -1;
      for (int i = 0; i < table_count; i++) begin
         if (hit < 0 && id_store[i] == w.id) hit = i;
      end
      case (w.op)
         OP_INSERT: begin
            if (table_count >= Capacity) begin
               r.status = ST_FULL;
               full_rejects++;
            end else begin
               key_val = int'(w.pos_y) + int'(w.z_idx) - int'(w.root);
               pos = 0;
               while (pos < table_count && int'(key_store[pos]) <= key_val) pos++;
               for (int i = table_count; i > pos; i--) begin
                  key_store[i]    = key_store[i-1];
                  id_store[i]     = id_store[i-1];
                  handle_store[i] = handle_store[i-1];
               end
               key_store[pos]    = key_val[KeyW-1:0];
               id_store[pos]     = w.id;
               handle_store[pos] = w.handle;
               table_count++;
            end
         end
         OP_REMOVE: begin
            if (hit < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               for (int i = hit; i + 1 < table_count; i++) begin
                  key_store[i]    = key_store[i+1];
                  id_store[i]     = id_store[i+1];
                  handle_store[i] = handle_store[i+1];
               end
               table_count--;
            end
         end
         OP_FIND: begin
            if (hit < 0) r.status = ST_NOT_FOUND;
            else r.handle = handle_store[hit];
         end
         default: begin
            if (table_count == 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               pos = int'(w.index);
               if (pos >= table_count) begin
                  pos = table_count - 1;
                  clamped_reads++;
               end
               r.handle = handle_store[pos];
            end
         end
      endcase
      r.total = table_count[TotalW-1:0];
      if (table_count > peak_count) peak_count = table_count;
      op_counts[w.op]++;
      return r;
   endfunction

   function automatic cmd_word_t make_word(op_type op, int py, int z, int root,
                                           int id, int handle, int index);
      cmd_word_t w;
      w.op     = op;
      w.pos_y  = py[CoordW-1:0];
      w.z_idx  = z[CoordW-1:0];
      w.root   = root[RootW-1:0];
      w.id     = id[IdW-1:0];
      w.handle = handle[HandleW-1:0];
      w.index  = index[PosW-1:0];
      return w;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // random word; ids lean on entries already held so lookups hit
   function automatic cmd_word_t random_word(int insert_pct);
      cmd_word_t w;
      int        r;
      r = $urandom_range(0, 99);
      if (r < insert_pct) begin
         w.op = OP_INSERT;
      end else begin
         case ($urandom_range(0, 2))
            0:       w.op = OP_REMOVE;
            1:       w.op = OP_FIND;
            default: w.op = OP_READ;
         endcase
      end
      // narrow keys give many ties, wide ones reach the extremes
      if ($urandom_range(0, 99) < 70) begin
         w.pos_y = CoordW'($signed($urandom_range(0, 8)) - 4);
         w.z_idx = CoordW'($signed($urandom_range(0, 4)) - 2);
         w.root  = RootW'($urandom_range(0, 3));
      end else begin
         w.pos_y = CoordW'($urandom);
         w.z_idx = CoordW'($urandom);
         w.root  = RootW'($urandom);
      end
      r = $urandom_range(0, 99);
      if (r < 50 && table_count > 0) w.id = id_store[$urandom_range(0, table_count - 1)];
      else if (r < 85) w.id = IdW'($urandom_range(0, IdPool - 1));
      else w.id = IdW'($urandom);
      w.handle = HandleW'($urandom);
      if ($urandom_range(0, 99) < 70) w.index = PosW'($urandom_range(0, table_count + 1));
      else w.index = PosW'($urandom);
      return w;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // drive one word and wait until it is taken
   task automatic send_word(input cmd_word_t w);
      @(negedge clock);
      start              <= 1'b1;
      req_operation      <= w.op;
      req_position_y     <= w.pos_y;
      req_z_index        <= w.z_idx;
      req_root_height    <= w.root;
      req_object_id      <= w.id;
      req_picture_handle <= w.handle;
      req_position_index <= w.index;
      @(posedge clock);
      while (busy) @(posedge clock);
      awaited_replies.push_back(draw_table_apply(w));
      words_sent++;
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic send_random(input int insert_pct);
      send_word(random_word(insert_pct));
      if (idle_enabled) idle_for(pick_gap());
   endtask

   // hold the sender until every reply is in
   task automatic drain_replies();
      idle_for(1);
      while (awaited_replies.size() != 0) @(posedge clock);
   endtask

   // check each strobed reply against the oldest awaited one
   always @(posedge clock) begin
      reply_word_t want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (awaited_replies.size() == 0) begin
            mismatch_count++;
            $display("[%0t] reply strobed with none awaited", $time);
         end else begin
            want = awaited_replies.pop_front();
            replies_checked++;
            if (rsp_result_handle !== want.handle)
               report_mismatch("result_handle", rsp_result_handle, want.handle);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_entry_total !== want.total)
               report_mismatch("entry_total", rsp_entry_total, want.total);
         end
      end
   end

   // every lookup on a table with nothing in it
   task automatic test_empty_table();
      send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 0));
      send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 16'hFFFF));
      send_word(make_word(OP_FIND, 0, 0, 0, 0, 0, 0));
      idle_for(3);
      send_word(make_word(OP_REMOVE, 0, 0, 0, 16'hFFFF, 0, 0));
   endtask

   // largest and smallest keys, ties kept in arrival order, reads past the end
   task automatic test_order_and_extremes();
      send_word(make_word(OP_INSERT, 32767, 32767, 0, 16'hFFFF, 16'hFFFF, 0));
      send_word(make_word(OP_INSERT, -32768, -32768, 32767, 0, 16'h0001, 0));
      send_word(make_word(OP_INSERT, 10, -10, 0, 5, 16'hAAAA, 0));
      idle_for(1);
      send_word(make_word(OP_INSERT, -20, 25, 5, 6, 16'h5555, 0));
      for (int i = 0; i < 5; i++) send_word(make_word(OP_READ, 0, 0, 0, 0, 0, i));
      send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 16'hFFFF));
   endtask

   // duplicate ids resolve to the first in table order, misses leave it alone
   task automatic test_lookup_cases();
      send_word(make_word(OP_INSERT, -100, 0, 0, 6, 16'h1234, 0));
      send_word(make_word(OP_FIND, 0, 0, 0, 6, 0, 0));
      send_word(make_word(OP_REMOVE, 0, 0, 0, 6, 0, 0));
      send_word(make_word(OP_FIND, 0, 0, 0, 6, 0, 0));
      idle_for(7);
      send_word(make_word(OP_FIND, 0, 0, 0, 16'h1234, 0, 0));
      send_word(make_word(OP_REMOVE, 0, 0, 0, 16'h1234, 0, 0));
      send_word(make_word(OP_REMOVE, 0, 0, 0, 16'hFFFF, 0, 0));
      send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 0));
   endtask

   // fill the table past full, then empty it again
   task automatic test_random_fill_drain();
      int n;
      for (int round = 0; round < 5; round++) begin
         idle_enabled = (round != 2);
         n = 0;
         while (table_count < Capacity && n < 400) begin
            send_random(85);
            n++;
         end
         repeat ($urandom_range(3, 8)) send_random(85);
         n = 0;
         while (table_count > 0 && n < 400) begin
            send_random(15);
            n++;
         end
         repeat ($urandom_range(2, 5)) send_random(10);
      end
      idle_enabled = 1'b1;
   endtask

   // long mixed run with the insert share drifting between blocks
   task automatic test_random_mixed();
      int pct;
      int blk;
      blk = 0;
      while (words_sent < RandomWords) begin
         pct = $urandom_range(25, 75);
         idle_enabled = (blk % 4 != 1);
         repeat (100) send_random(pct);
         if (blk == 3) drain_replies();
         blk++;
      end
      idle_enabled = 1'b1;
   endtask

   initial begin
      reset              = 1'b1;
      start              = 1'b0;
      req_operation      = OP_INSERT;
      req_position_y     = '0;
      req_z_index        = '0;
      req_root_height    = '0;
      req_object_id      = '0;
      req_picture_handle = '0;
      req_position_index = '0;
      table_count        = 0;
      idle_enabled       = 1'b1;
      mismatch_count     = 0;
      words_sent         = 0;
      replies_checked    = 0;
      full_rejects       = 0;
      clamped_reads      = 0;
      peak_count         = 0;
      foreach (op_counts[i]) op_counts[i] = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_order_and_extremes();
      test_lookup_cases();
      test_random_fill_drain();
      test_random_mixed();

      // let the last replies come out
      drain_replies();
      repeat (8) @(posedge clock);

      $display("covered %0d words: %0d inserts (%0d refused on a full table), %0d removes,",
               words_sent, op_counts[OP_INSERT], full_rejects, op_counts[OP_REMOVE]);
      $display("%0d finds, %0d reads (%0d clamped), %0d replies checked, peak fill %0d",
               op_counts[OP_FIND], op_counts[OP_READ], clamped_reads, replies_checked,
               peak_count);
      if (mismatch_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/sil_pkg.sv
hw/rtl/sil_cell.sv
hw/rtl/sorted_insertion_list_unit.sv
tb/tb_sorted_insertion_list_unit.sv
